@@ rtl/core/lwpc_pkg.sv @@
// Shared types, codes and helpers of the LRU write-back page cache.
package lwpc_pkg;

  localparam int CNT_BITS   = 32;
  localparam int STAMP_BITS = 64;
  localparam int WAYS_BITS  = 5;
  localparam int CNT_W      = 7;
  localparam logic [WAYS_BITS-1:0] WAYS_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_READ_DATA  = 3'd0,
    K_WRITE_DONE = 3'd1,
    K_WRITEBACK  = 3'd2,
    K_FETCH      = 3'd3,
    K_FLUSH_DONE = 3'd4,
    K_REJECT     = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_DEC,
    S_WB,
    S_INST,
    S_FCNT,
    S_FEMIT,
    S_FDONE
  } state_t;

  // Saturating increment of an event counter
  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
    sat_inc = (&c) ? c : c + 1'b1;
  endfunction

  // Saturating add of a small count to an event counter
  function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] c,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_BITS:0] s;
    s = {1'b0, c} + {{(CNT_BITS+1-CNT_W){1'b0}}, n};
    sat_add = s[CNT_BITS] ? {CNT_BITS{1'b1}} : s[CNT_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/lru_writeback_page_cache_top.sv @@
// Top level of the fully associative LRU write-back page cache.
//
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tuser op, tdata page_id, write_data
// out_     out  out_tvalid/out_tready  tuser kind, tlast last, tdata rest
// cfg_     in   cfg_wr_en              cfg_wr_data active_ways
//
// Read and write step through accept (the idle state that takes the item),
// dispatch, one scan step per slot through the single tag/stamp read port and
// stamp comparator, decide and install. A dirty victim adds a writeback step
// before install. Flush runs a count pass, then an emit pass that sends a
// writeback for each valid dirty slot, then a done result. Fill and reject are answered in dispatch.
// Synchronous active-low reset; no clearing pass. A stalled output stalls the
// sequencer at its next result; in_tready is high only when idle.
module lru_writeback_page_cache_top #(
  parameter int SLOTS     = 16,
  parameter int DATA_BITS = 64,
  parameter int PAGE_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // op
  input  logic [1:0] in_tuser,
  // page_id, write_data, zero pad
  input  logic [((PAGE_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // kind
  output logic [2:0] out_tuser,
  output logic out_tlast,
  // page_out, data_out, was_hit, hit_count, miss_count, eviction_count,
  // writeback_count, zero pad
  output logic [((PAGE_BITS + DATA_BITS + 1 + 4 * lwpc_pkg::CNT_BITS + 7) / 8) * 8 - 1:0]
               out_tdata,
  input  logic cfg_wr_en,
  input  logic [lwpc_pkg::WAYS_BITS-1:0] cfg_wr_data
);

  localparam int IN_W   = ((PAGE_BITS + DATA_BITS + 7) / 8) * 8;
  localparam int OUT_RAW = PAGE_BITS + DATA_BITS + 1 + 4 * lwpc_pkg::CNT_BITS;
  localparam int OUT_W  = ((OUT_RAW + 7) / 8) * 8;
  localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW     = lwpc_pkg::CNT_W;
  localparam int SB     = lwpc_pkg::STAMP_BITS;
  localparam int NB     = lwpc_pkg::CNT_BITS;
  localparam int RES_W  = OUT_W + 3 + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // Slot storage
  logic [PAGE_BITS-1:0] tag_r   [SLOTS];
  logic [DATA_BITS-1:0] data_r  [SLOTS];
  logic [SB-1:0]        stamp_r [SLOTS];
  logic [SLOTS-1:0]     valid_r;
  logic [SLOTS-1:0]     dirty_r;

  // Control and counters
  lwpc_pkg::state_t state_r, state_nxt;
  logic [lwpc_pkg::WAYS_BITS-1:0] ways_r;
  logic [SB-1:0]        clk_r;
  logic                 pend_r;
  logic [IW-1:0]        pend_slot_r;
  logic [NB-1:0]        hits_r, misses_r, evicts_r, wbs_r;

  // Current item
  logic [1:0]           op_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [DATA_BITS-1:0] wdata_r;

  // Scan results
  logic [IW-1:0]        idx_r;
  logic                 hit_r;
  logic [IW-1:0]        hit_idx_r;
  logic                 free_found_r;
  logic [IW-1:0]        free_idx_r;
  logic                 vic_found_r;
  logic [IW-1:0]        vic_idx_r;
  logic [SB-1:0]        vic_stamp_r;
  logic [CW-1:0]        used_r;
  logic [CW-1:0]        dcnt_r;
  logic [IW-1:0]        slot_r;

  // Shared read port
  logic [IW-1:0]        rd_idx;
  logic [PAGE_BITS-1:0] rd_tag;
  logic [DATA_BITS-1:0] rd_data;
  logic [SB-1:0]        rd_stamp;
  logic                 rd_valid, rd_dirty;

  // Result producer
  logic                 res_valid, res_ready;
  logic [2:0]           res_kind;
  logic [PAGE_BITS-1:0] res_page;
  logic [DATA_BITS-1:0] res_data;
  logic                 res_hit, res_last;
  logic [OUT_W-1:0]     res_tdata;
  logic [RES_W-1:0]     res_bus, q_bus;

  logic                 in_fire, scan_end, is_reject, miss_free, miss_evict;
  logic [CW-1:0]        eff_ways;
  logic [1:0]           in_op;

  assign in_op     = in_tuser;
  assign in_tready = (state_r == lwpc_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign scan_end  = (idx_r == LAST_IDX);
  assign is_reject = pend_r != (op_r == lwpc_pkg::OP_FILL);

  // Clamp active ways to one..SLOTS
  always_comb begin
    if (ways_r == '0) begin
      eff_ways = CW'(1);
    end else if (CW'(ways_r) > CW'(SLOTS)) begin
      eff_ways = CW'(SLOTS);
    end else begin
      eff_ways = CW'(ways_r);
    end
  end

  assign miss_free  = (used_r < eff_ways) && free_found_r;
  assign miss_evict = !miss_free && vic_found_r;

  // Select the slot addressed by the current step
  always_comb begin
    case (state_r)
      lwpc_pkg::S_DISP: rd_idx = pend_slot_r;
      lwpc_pkg::S_WB,
      lwpc_pkg::S_INST: rd_idx = slot_r;
      default:          rd_idx = idx_r;
    endcase
  end

  assign rd_tag   = tag_r[rd_idx];
  assign rd_data  = data_r[rd_idx];
  assign rd_stamp = stamp_r[rd_idx];
  assign rd_valid = valid_r[rd_idx];
  assign rd_dirty = dirty_r[rd_idx];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lwpc_pkg::S_IDLE: begin
        if (in_fire) state_nxt = lwpc_pkg::S_DISP;
      end
      lwpc_pkg::S_DISP: begin
        if (is_reject || op_r == lwpc_pkg::OP_FILL) begin
          if (res_ready) state_nxt = lwpc_pkg::S_IDLE;
        end else if (op_r == lwpc_pkg::OP_FLUSH) begin
          state_nxt = lwpc_pkg::S_FCNT;
        end else begin
          state_nxt = lwpc_pkg::S_SCAN;
        end
      end
      lwpc_pkg::S_SCAN: begin
        if (scan_end) state_nxt = lwpc_pkg::S_DEC;
      end
      lwpc_pkg::S_DEC: begin
        if (!hit_r && miss_evict && dirty_r[vic_idx_r]) state_nxt = lwpc_pkg::S_WB;
        else state_nxt = lwpc_pkg::S_INST;
      end
      lwpc_pkg::S_WB: begin
        if (res_ready) state_nxt = lwpc_pkg::S_INST;
      end
      lwpc_pkg::S_INST: begin
        if (res_ready) state_nxt = lwpc_pkg::S_IDLE;
      end
      lwpc_pkg::S_FCNT: begin
        if (scan_end) state_nxt = lwpc_pkg::S_FEMIT;
      end
      lwpc_pkg::S_FEMIT: begin
        if (scan_end && (!(rd_valid && rd_dirty) || res_ready)) begin
          state_nxt = lwpc_pkg::S_FDONE;
        end
      end
      lwpc_pkg::S_FDONE: begin
        if (res_ready) state_nxt = lwpc_pkg::S_IDLE;
      end
      default: state_nxt = lwpc_pkg::S_IDLE;
    endcase
  end

  // Result fields for each step
  always_comb begin
    res_valid = 1'b0;
    res_kind  = lwpc_pkg::K_READ_DATA;
    res_page  = '0;
    res_data  = '0;
    res_hit   = 1'b0;
    res_last  = 1'b1;
    case (state_r)
      lwpc_pkg::S_DISP: begin
        if (is_reject) begin
          res_valid = 1'b1;
          res_kind  = lwpc_pkg::K_REJECT;
          res_page  = page_r;
        end else if (op_r == lwpc_pkg::OP_FILL) begin
          res_valid = 1'b1;
          res_kind  = lwpc_pkg::K_READ_DATA;
          res_page  = rd_tag;
          res_data  = wdata_r;
        end
      end
      lwpc_pkg::S_WB,
      lwpc_pkg::S_FEMIT: begin
        res_valid = (state_r == lwpc_pkg::S_WB) || (rd_valid && rd_dirty);
        res_kind  = lwpc_pkg::K_WRITEBACK;
        res_page  = rd_tag;
        res_data  = rd_data;
        res_last  = 1'b0;
      end
      lwpc_pkg::S_INST: begin
        res_valid = 1'b1;
        res_page  = page_r;
        res_hit   = hit_r;
        if (op_r == lwpc_pkg::OP_WRITE) begin
          res_kind = lwpc_pkg::K_WRITE_DONE;
          res_data = wdata_r;
        end else if (hit_r) begin
          res_kind = lwpc_pkg::K_READ_DATA;
          res_data = rd_data;
        end else begin
          res_kind = lwpc_pkg::K_FETCH;
        end
      end
      lwpc_pkg::S_FDONE: begin
        res_valid = 1'b1;
        res_kind  = lwpc_pkg::K_FLUSH_DONE;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Pack the result: tdata, then kind, then last
  always_comb begin
    res_tdata = '0;
    res_tdata[OUT_RAW-1:0] = {wbs_r, evicts_r, misses_r, hits_r, res_hit, res_data, res_page};
  end
  assign res_bus = {res_last, res_kind, res_tdata};

  lwpc_out_reg #(
    .W (RES_W)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_valid (res_valid),
    .ld_ready (res_ready),
    .ld_data  (res_bus),
    .q_valid  (out_tvalid),
    .q_ready  (out_tready),
    .q_data   (q_bus)
  );

  assign out_tdata = q_bus[OUT_W-1:0];
  assign out_tuser = q_bus[OUT_W+2:OUT_W];
  assign out_tlast = q_bus[RES_W-1];

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lwpc_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)         ways_r <= lwpc_pkg::WAYS_RESET;
    else if (cfg_wr_en) ways_r <= cfg_wr_data;
  end

  // Control state: valid, dirty, clock, pending fill, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      dirty_r     <= '0;
      clk_r       <= '0;
      pend_r      <= 1'b0;
      pend_slot_r <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      wbs_r       <= '0;
    end else begin
      case (state_r)
        lwpc_pkg::S_DISP: begin
          if (!is_reject && op_r == lwpc_pkg::OP_FILL && res_ready) begin
            valid_r[pend_slot_r] <= 1'b1;
            dirty_r[pend_slot_r] <= 1'b0;
            pend_r               <= 1'b0;
          end else if (!is_reject && op_r != lwpc_pkg::OP_FLUSH &&
                       op_r != lwpc_pkg::OP_FILL) begin
            clk_r <= clk_r + 1'b1;
          end
        end
        lwpc_pkg::S_DEC: begin
          if (hit_r) begin
            hits_r <= lwpc_pkg::sat_inc(hits_r);
          end else begin
            misses_r <= lwpc_pkg::sat_inc(misses_r);
            if (miss_evict) begin
              evicts_r <= lwpc_pkg::sat_inc(evicts_r);
              if (dirty_r[vic_idx_r]) wbs_r <= lwpc_pkg::sat_inc(wbs_r);
              valid_r[vic_idx_r] <= 1'b0;
              dirty_r[vic_idx_r] <= 1'b0;
            end
          end
        end
        lwpc_pkg::S_INST: begin
          if (res_ready) begin
            if (op_r == lwpc_pkg::OP_WRITE) begin
              valid_r[slot_r] <= 1'b1;
              dirty_r[slot_r] <= 1'b1;
            end else if (!hit_r) begin
              valid_r[slot_r] <= 1'b0;
              dirty_r[slot_r] <= 1'b0;
              pend_r          <= 1'b1;
              pend_slot_r     <= slot_r;
            end
          end
        end
        lwpc_pkg::S_FCNT: begin
          if (scan_end) begin
            wbs_r <= lwpc_pkg::sat_add(wbs_r, dcnt_r + CW'(rd_valid && rd_dirty));
          end
        end
        lwpc_pkg::S_FEMIT: begin
          if (rd_valid && rd_dirty && res_ready) dirty_r[idx_r] <= 1'b0;
        end
        default: begin
          pend_r <= pend_r;
        end
      endcase
    end
  end

  // Item latch, scan unit and slot payload
  always_ff @(posedge clk) begin
    case (state_r)
      lwpc_pkg::S_IDLE: begin
        if (in_fire) begin
          op_r    <= in_op;
          page_r  <= in_tdata[PAGE_BITS-1:0];
          wdata_r <= in_tdata[PAGE_BITS+DATA_BITS-1:PAGE_BITS];
        end
      end
      lwpc_pkg::S_DISP: begin
        idx_r        <= '0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
        vic_found_r  <= 1'b0;
        used_r       <= '0;
        dcnt_r       <= '0;
        if (!is_reject && op_r == lwpc_pkg::OP_FILL && res_ready) begin
          data_r[pend_slot_r] <= wdata_r;
        end
      end
      lwpc_pkg::S_SCAN: begin
        idx_r <= idx_r + 1'b1;
        if (rd_valid) begin
          used_r <= used_r + 1'b1;
          if (!hit_r && rd_tag == page_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= idx_r;
          end
          if (!vic_found_r || rd_stamp < vic_stamp_r) begin
            vic_found_r <= 1'b1;
            vic_idx_r   <= idx_r;
            vic_stamp_r <= rd_stamp;
          end
        end else if (!free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= idx_r;
        end
      end
      lwpc_pkg::S_DEC: begin
        if (hit_r)           slot_r <= hit_idx_r;
        else if (miss_free)  slot_r <= free_idx_r;
        else if (miss_evict) slot_r <= vic_idx_r;
        else if (free_found_r) slot_r <= free_idx_r;
        else                 slot_r <= '0;
      end
      lwpc_pkg::S_INST: begin
        if (res_ready) begin
          stamp_r[slot_r] <= clk_r;
          if (!hit_r) tag_r[slot_r] <= page_r;
          if (op_r == lwpc_pkg::OP_WRITE) data_r[slot_r] <= wdata_r;
        end
      end
      lwpc_pkg::S_FCNT: begin
        if (rd_valid && rd_dirty) dcnt_r <= dcnt_r + 1'b1;
        idx_r <= scan_end ? '0 : idx_r + 1'b1;
      end
      lwpc_pkg::S_FEMIT: begin
        if (!(rd_valid && rd_dirty) || res_ready) idx_r <= idx_r + 1'b1;
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

endmodule

@@ rtl/core/lwpc_out_reg.sv @@
// Output holding register that decouples result production from the sink.
module lwpc_out_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         ld_valid,
  output logic         ld_ready,
  input  logic [W-1:0] ld_data,
  output logic         q_valid,
  input  logic         q_ready,
  output logic [W-1:0] q_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign ld_ready = !valid_r || q_ready;
  assign q_valid  = valid_r;
  assign q_data   = data_r;

  // Hold a result until its transfer, load the next one behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld_ready) begin
      valid_r <= ld_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ready && ld_valid) begin
      data_r <= ld_data;
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the LRU write-back page cache: a predictor and result scoreboard.
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS = 16;
  localparam int IN_W  = 96;
  localparam int OUT_W = 232;

  typedef struct {
    lwpc_pkg::kind_t kind;
    logic [31:0] page;
    logic [63:0] data;
    logic        hit;
    logic        last;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
    logic [31:0] wbacks;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [lwpc_pkg::WAYS_BITS-1:0] cfg_wr_data = '0;

  lru_writeback_page_cache_top #(.SLOTS(SLOTS), .DATA_BITS(64), .PAGE_BITS(32)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tlast(out_tlast), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state
  logic [31:0] pc_tag   [SLOTS];
  logic [63:0] pc_data  [SLOTS];
  logic        pc_valid [SLOTS];
  logic        pc_dirty [SLOTS];
  logic [63:0] pc_stamp [SLOTS];
  logic [63:0] pc_clock;
  logic        pc_fill_wait;
  int          pc_fill_slot;
  logic [31:0] pc_hits, pc_misses, pc_evicts, pc_wbacks;
  logic [4:0]  pc_ways;

  cache_result_t cache_results_q[$];
  int  error_count = 0;
  int  ready_hold = 0;
  bit  long_gaps = 1'b1;

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (&c) ? c : c + 32'd1;
  endfunction

  // Compute the results of one accepted item and queue them
  task automatic cache_predict(input lwpc_pkg::op_t op, input logic [31:0] page,
                               input logic [63:0] data);
    cache_result_t r[$];
    cache_result_t one;
    int idx, used, free_slot, victim, ways;
    idx = -1;
    if (pc_fill_wait != (op == lwpc_pkg::OP_FILL)) begin
      r.push_back('{lwpc_pkg::K_REJECT, page, 64'd0, 1'b0, 1'b1, 0, 0, 0, 0});
    end else if (op == lwpc_pkg::OP_FILL) begin
      pc_data[pc_fill_slot] = data;
      pc_valid[pc_fill_slot] = 1'b1;
      pc_dirty[pc_fill_slot] = 1'b0;
      pc_fill_wait = 1'b0;
      r.push_back('{lwpc_pkg::K_READ_DATA, pc_tag[pc_fill_slot], data, 1'b0, 1'b1,
                    0, 0, 0, 0});
    end else if (op == lwpc_pkg::OP_FLUSH) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (pc_valid[i] && pc_dirty[i]) begin
          r.push_back('{lwpc_pkg::K_WRITEBACK, pc_tag[i], pc_data[i], 1'b0, 1'b0,
                        0, 0, 0, 0});
          pc_wbacks = bump(pc_wbacks);
          pc_dirty[i] = 1'b0;
        end
      end
      r.push_back('{lwpc_pkg::K_FLUSH_DONE, 32'd0, 64'd0, 1'b0, 1'b1, 0, 0, 0, 0});
    end else begin
      pc_clock = pc_clock + 64'd1;
      for (int i = 0; i < SLOTS; i++)
        if (idx < 0 && pc_valid[i] && pc_tag[i] == page) idx = i;
      if (idx >= 0) begin
        pc_hits = bump(pc_hits);
        pc_stamp[idx] = pc_clock;
        if (op == lwpc_pkg::OP_READ) begin
          r.push_back('{lwpc_pkg::K_READ_DATA, page, pc_data[idx], 1'b1, 1'b1, 0, 0, 0, 0});
        end else begin
          pc_data[idx] = data;
          pc_dirty[idx] = 1'b1;
          r.push_back('{lwpc_pkg::K_WRITE_DONE, page, data, 1'b1, 1'b1, 0, 0, 0, 0});
        end
      end else begin
        pc_misses = bump(pc_misses);
        // Pick a free slot, or evict the oldest stamp (lowest index on ties)
        ways = (pc_ways == 0) ? 1 : (pc_ways > SLOTS) ? SLOTS : pc_ways;
        used = 0; free_slot = -1; victim = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (pc_valid[i]) begin
            used++;
            if (victim < 0 || pc_stamp[i] < pc_stamp[victim]) victim = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (used < ways && free_slot >= 0) idx = free_slot;
        else if (victim < 0) idx = (free_slot < 0) ? 0 : free_slot;
        else begin
          pc_evicts = bump(pc_evicts);
          if (pc_dirty[victim]) begin
            r.push_back('{lwpc_pkg::K_WRITEBACK, pc_tag[victim], pc_data[victim], 1'b0, 1'b0,
                          0, 0, 0, 0});
            pc_wbacks = bump(pc_wbacks);
          end
          pc_valid[victim] = 1'b0;
          pc_dirty[victim] = 1'b0;
          idx = victim;
        end
        pc_tag[idx] = page;
        pc_stamp[idx] = pc_clock;
        if (op == lwpc_pkg::OP_READ) begin
          pc_valid[idx] = 1'b0;
          pc_dirty[idx] = 1'b0;
          pc_fill_wait = 1'b1;
          pc_fill_slot = idx;
          r.push_back('{lwpc_pkg::K_FETCH, page, 64'd0, 1'b0, 1'b1, 0, 0, 0, 0});
        end else begin
          pc_data[idx] = data;
          pc_valid[idx] = 1'b1;
          pc_dirty[idx] = 1'b1;
          r.push_back('{lwpc_pkg::K_WRITE_DONE, page, data, 1'b0, 1'b1, 0, 0, 0, 0});
        end
      end
    end
    // Counters as they stand after the whole item
    foreach (r[k]) begin
      one = r[k];
      one.hits = pc_hits; one.misses = pc_misses;
      one.evicts = pc_evicts; one.wbacks = pc_wbacks;
      cache_results_q.push_back(one);
    end
  endtask

  // Clock and run limit
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end

  // Receiver: random stalls, or a counted long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        out_tready <= 1'b0;
        ready_hold--;
      end else if (n > 0) begin
        out_tready <= 1'b0;
        n--;
      end else if ($urandom_range(0, 9) < 3) begin
        out_tready <= 1'b0;
        n = long_gaps && ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    cache_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (cache_results_q.size() == 0) begin
        $display("%0t: expected no result, actual kind %0d page %h", $time, out_tuser,
                 out_tdata[31:0]);
        error_count++;
      end else begin
        e = cache_results_q.pop_front();
        if (out_tuser != e.kind || out_tlast != e.last || out_tdata[31:0] != e.page ||
            out_tdata[95:32] != e.data || out_tdata[96] != e.hit ||
            out_tdata[128:97] != e.hits || out_tdata[160:129] != e.misses ||
            out_tdata[192:161] != e.evicts || out_tdata[224:193] != e.wbacks ||
            out_tdata[231:225] != '0) begin
          $display("%0t: mismatch expected kind %0d last %b page %h data %h hit %b cnt %0d/%0d/%0d/%0d",
                   $time, e.kind, e.last, e.page, e.data, e.hit,
                   e.hits, e.misses, e.evicts, e.wbacks);
          $display("%0t:          actual kind %0d last %b page %h data %h hit %b cnt %0d/%0d/%0d/%0d",
                   $time, out_tuser, out_tlast, out_tdata[31:0], out_tdata[95:32], out_tdata[96],
                   out_tdata[128:97], out_tdata[160:129], out_tdata[192:161], out_tdata[224:193]);
          error_count++;
        end
      end
    end
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input lwpc_pkg::op_t op, input logic [31:0] page,
                           input logic [63:0] data);
    int gap;
    gap = (long_gaps && $urandom_range(0, 24) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(0, 3) == 0 ? 1 : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {data, page};
    do @(posedge clk); while (!in_tready);
    cache_predict(op, page, data);
  endtask

  // Lower valid and wait until every predicted result has arrived
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (cache_results_q.size() != 0) @(posedge clk);
  endtask

  // Write the way count once the block is idle
  task automatic set_ways(input logic [4:0] w);
    drain();
    repeat (80) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 5'($urandom);
    pc_ways = w;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_item(lwpc_pkg::OP_FILL, 32'h0, 64'h0);             // fill with nothing pending
    send_item(lwpc_pkg::OP_FLUSH, 32'h0, 64'h0);            // flush of an empty cache
    send_item(lwpc_pkg::OP_WRITE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(lwpc_pkg::OP_READ, 32'hFFFF_FFFF, 64'h0);     // read hit
    send_item(lwpc_pkg::OP_READ, 32'h0, 64'h0);             // read miss
    send_item(lwpc_pkg::OP_WRITE, 32'h1, 64'h1);            // rejected while fill pending
    send_item(lwpc_pkg::OP_FLUSH, 32'h2, 64'h0);            // rejected while fill pending
    send_item(lwpc_pkg::OP_READ, 32'h3, 64'h0);             // rejected while fill pending
    send_item(lwpc_pkg::OP_FILL, 32'h5A5A_5A5A, 64'hA5A5_A5A5_0000_FFFF);
    send_item(lwpc_pkg::OP_READ, 32'h0, 64'h0);
    send_item(lwpc_pkg::OP_WRITE, 32'h0, 64'h0);            // write hit
    send_item(lwpc_pkg::OP_FLUSH, 32'h0, 64'h0);            // two dirty pages
    set_ways(5'd2);
    send_item(lwpc_pkg::OP_WRITE, 32'h10, 64'h1111);        // ways lowered to occupancy
    send_item(lwpc_pkg::OP_WRITE, 32'h11, 64'h2222);
    send_item(lwpc_pkg::OP_READ, 32'h12, 64'h0);            // dirty victim then fetch
    send_item(lwpc_pkg::OP_FILL, 32'h0, 64'h3333);
    send_item(lwpc_pkg::OP_FLUSH, 32'h0, 64'h0);
    set_ways(5'd0);                                         // acts as one way
    send_item(lwpc_pkg::OP_WRITE, 32'h20, 64'hDEAD_BEEF_0BAD_F00D);
    send_item(lwpc_pkg::OP_WRITE, 32'h21, 64'h8000_0000_0000_0001);
    send_item(lwpc_pkg::OP_READ, 32'h20, 64'h0);
    send_item(lwpc_pkg::OP_FILL, 32'h0, 64'h7FFF_FFFF_FFFF_FFFE);
    set_ways(5'd31);                                        // acts as all slots
  endtask

  // Mostly well-formed traffic: fills answer misses, pages from a small pool
  task automatic random_items(input int count);
    int pick;
    logic [31:0] page;
    lwpc_pkg::op_t op;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      page = ($urandom_range(0, 9) == 0) ? $urandom : 32'(($urandom_range(0, 23) * 32'h0101_0011));
      if (pc_fill_wait) op = (pick < 90) ? lwpc_pkg::OP_FILL
                                         : lwpc_pkg::op_t'($urandom_range(0, 3));
      else if (pick < 45) op = lwpc_pkg::OP_READ;
      else if (pick < 85) op = lwpc_pkg::OP_WRITE;
      else if (pick < 93) op = lwpc_pkg::OP_FLUSH;
      else op = lwpc_pkg::OP_FILL;
      send_item(op, page, rand64());
    end
  endtask

  task automatic test_ways_sweep();
    logic [4:0] w [5] = '{5'd1, 5'd4, 5'd16, 5'd7, 5'd17};
    foreach (w[k]) begin
      set_ways(w[k]);
      random_items(60);
    end
  endtask

  task automatic test_backpressure();
    drain();
    ready_hold = 400;
    random_items(25);
    drain();                     // sender waits for every result
    random_items(20);
  endtask

  task automatic test_random();
    set_ways(5'd3);
    random_items(40);
    long_gaps = 1'b0;            // a stretch without long gaps or hold-offs
    set_ways(5'd12);
    random_items(40);
    long_gaps = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      pc_valid[i] = 1'b0; pc_dirty[i] = 1'b0;
    end
    pc_clock = '0; pc_fill_wait = 1'b0; pc_fill_slot = 0;
    pc_hits = '0; pc_misses = '0; pc_evicts = '0; pc_wbacks = '0;
    pc_ways = lwpc_pkg::WAYS_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_ways_sweep();
    test_backpressure();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (error_count == 0 && cache_results_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
